// ===== rtl/tlps_pkg.sv =====
// ----------------------------------------------------------------------------
// tlps_pkg
// phase table, lamp codes and register indexes of the pedestrian sequencer
// ----------------------------------------------------------------------------
package tlps_pkg;

  // lamp bit positions in the six-bit lamp word
  localparam logic [5:0] LAMP_CR = 6'b000001;
  localparam logic [5:0] LAMP_CY = 6'b000010;
  localparam logic [5:0] LAMP_CG = 6'b000100;
  localparam logic [5:0] LAMP_WR = 6'b001000;
  localparam logic [5:0] LAMP_WY = 6'b010000;
  localparam logic [5:0] LAMP_WG = 6'b100000;
  localparam logic [5:0] LAMP_NONE = 6'b000000;

  // configuration register indexes
  localparam logic [1:0] REG_LONG_PHASE_TICKS = 2'd0;
  localparam logic [1:0] REG_BLINK_HALF_TICKS = 2'd1;
  localparam logic [1:0] REG_BLINK_CYCLES     = 2'd2;

  // register reset values
  localparam logic [15:0] LONG_PHASE_TICKS_RST = 16'd5000;
  localparam logic [15:0] BLINK_HALF_TICKS_RST = 16'd500;
  localparam logic [3:0]  BLINK_CYCLES_RST     = 4'd5;

  typedef enum logic [1:0] {
    COL_GREEN  = 2'd0,
    COL_YELLOW = 2'd1,
    COL_RED    = 2'd2
  } colour_e;

  typedef enum logic [4:0] {
    // normal loop
    PH_NORM_GREEN = 5'd0,
    PH_NORM_YEL_A = 5'd1,
    PH_NORM_RED   = 5'd2,
    PH_NORM_YEL_B = 5'd3,
    // request while car red
    PH_RR_WALK    = 5'd4,
    PH_RR_BLINK   = 5'd5,
    PH_RR_GREEN   = 5'd6,
    PH_RR_CLEAR   = 5'd7,
    // request while car yellow
    PH_RY_CLEAR   = 5'd8,
    PH_RY_WALK    = 5'd9,
    PH_RY_BLINK   = 5'd10,
    PH_RY_GREEN   = 5'd11,
    PH_RY_END     = 5'd12,
    // request while car green
    PH_RG_CLEAR   = 5'd13,
    PH_RG_WALK    = 5'd14,
    PH_RG_BLINK   = 5'd15,
    PH_RG_GREEN   = 5'd16
  } phase_e;

  typedef struct packed {
    phase_e      nxt;
    logic        resume;
    logic        blinking;
    logic [5:0]  steady;
    logic [5:0]  flashing;
    colour_e     colour;
  } phase_desc_t;

  function automatic phase_desc_t mk(phase_e nxt, logic resume, logic blinking,
                                     logic [5:0] steady, logic [5:0] flashing,
                                     colour_e colour);
    phase_desc_t d;
    d.nxt      = nxt;
    d.resume   = resume;
    d.blinking = blinking;
    d.steady   = steady;
    d.flashing = flashing;
    d.colour   = colour;
    return d;
  endfunction

  function automatic phase_desc_t phase_desc(phase_e ph);
    phase_desc_t d;
    unique case (ph)
      PH_NORM_GREEN: d = mk(PH_NORM_YEL_A, 1'b0, 1'b0, LAMP_CG | LAMP_WR, LAMP_NONE,
                            COL_GREEN);
      PH_NORM_YEL_A: d = mk(PH_NORM_RED, 1'b0, 1'b1, LAMP_WR, LAMP_CY, COL_YELLOW);
      PH_NORM_RED:   d = mk(PH_NORM_YEL_B, 1'b0, 1'b0, LAMP_CR | LAMP_WG, LAMP_NONE,
                            COL_RED);
      PH_NORM_YEL_B: d = mk(PH_NORM_GREEN, 1'b0, 1'b1, LAMP_WR, LAMP_CY, COL_YELLOW);
      PH_RR_WALK:    d = mk(PH_RR_BLINK, 1'b0, 1'b0, LAMP_CR | LAMP_WG, LAMP_NONE,
                            COL_GREEN);
      PH_RR_BLINK:   d = mk(PH_RR_GREEN, 1'b0, 1'b1, LAMP_WG, LAMP_CY, COL_GREEN);
      PH_RR_GREEN:   d = mk(PH_RR_CLEAR, 1'b0, 1'b0, LAMP_CG | LAMP_WR, LAMP_NONE,
                            COL_GREEN);
      PH_RR_CLEAR:   d = mk(PH_NORM_GREEN, 1'b1, 1'b1, LAMP_WR, LAMP_CY | LAMP_WY,
                            COL_GREEN);
      PH_RY_CLEAR:   d = mk(PH_RY_WALK, 1'b0, 1'b1, LAMP_WR, LAMP_CY | LAMP_WY,
                            COL_GREEN);
      PH_RY_WALK:    d = mk(PH_RY_BLINK, 1'b0, 1'b0, LAMP_CR | LAMP_WG, LAMP_NONE,
                            COL_GREEN);
      PH_RY_BLINK:   d = mk(PH_RY_GREEN, 1'b0, 1'b1, LAMP_WG, LAMP_CY | LAMP_WY,
                            COL_GREEN);
      PH_RY_GREEN:   d = mk(PH_RY_END, 1'b0, 1'b0, LAMP_CG | LAMP_WR, LAMP_NONE,
                            COL_GREEN);
      PH_RY_END:     d = mk(PH_NORM_GREEN, 1'b1, 1'b1, LAMP_WR, LAMP_CY, COL_GREEN);
      PH_RG_CLEAR:   d = mk(PH_RG_WALK, 1'b0, 1'b1, LAMP_CG | LAMP_WR,
                            LAMP_CY | LAMP_WY, COL_GREEN);
      PH_RG_WALK:    d = mk(PH_RG_BLINK, 1'b0, 1'b0, LAMP_CR | LAMP_WG, LAMP_NONE,
                            COL_GREEN);
      PH_RG_BLINK:   d = mk(PH_RG_GREEN, 1'b0, 1'b1, LAMP_WG, LAMP_CY | LAMP_WY,
                            COL_GREEN);
      PH_RG_GREEN:   d = mk(PH_NORM_GREEN, 1'b1, 1'b0, LAMP_CG | LAMP_WR, LAMP_NONE,
                            COL_GREEN);
      default:       d = mk(PH_NORM_YEL_A, 1'b0, 1'b0, LAMP_CG | LAMP_WR, LAMP_NONE,
                            COL_GREEN);
    endcase
    return d;
  endfunction

  // the four phases of the normal loop
  function automatic logic is_normal(phase_e ph);
    return (ph == PH_NORM_GREEN) || (ph == PH_NORM_YEL_A) ||
           (ph == PH_NORM_RED) || (ph == PH_NORM_YEL_B);
  endfunction

endpackage

// ===== rtl/traffic_light_pedestrian_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// traffic_light_pedestrian_sequencer_top
// six-lamp traffic light sequencer with a pedestrian request button
// ----------------------------------------------------------------------------
// Each input word carries a timer tick flag and a button flag; each accepted
// word yields exactly one result word with the six lamp bits and a flag that
// is high while a pedestrian sequence runs. The block takes one word per
// cycle: the phase counters and lamp decode sit between the state registers
// and a single output register, and a new word is taken in the same cycle
// the held result is taken, so only a stall on the output side slows it.
// Results appear in the cycle after acceptance. The normal loop runs
// car green, car yellow blinking, car red with walk green, car yellow
// blinking. A press during the normal loop starts a pedestrian sequence
// picked by the current car colour and saves the time left in the running
// phase; when the sequence ends that phase resumes where it stopped. A press
// together with a tick drops the tick. Presses during a sequence are ignored.
// Writes take effect at the next phase load (blink half register: next half),
// never on a running count, and a register value of zero acts as one.
module traffic_light_pedestrian_sequencer_top
  import tlps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input word
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        tick_i,
  input  logic        press_i,
  // result word
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        car_red_o,
  output logic        car_yellow_o,
  output logic        car_green_o,
  output logic        walk_red_o,
  output logic        walk_yellow_o,
  output logic        walk_green_o,
  output logic        serving_request_o
);

  // configuration registers
  logic [15:0] long_ticks_q;
  logic [15:0] half_ticks_q;
  logic [3:0]  blink_cycles_q;

  // sequencer state
  phase_e      phase_q, phase_d;
  colour_e     colour_q, colour_d;
  logic [15:0] ticks_q, ticks_d;
  logic [3:0]  blinks_q, blinks_d;
  logic        lit_q, lit_d;
  logic [1:0]  sv_phase_q, sv_phase_d;
  logic [15:0] sv_ticks_q, sv_ticks_d;
  logic [3:0]  sv_blinks_q, sv_blinks_d;
  logic        sv_lit_q, sv_lit_d;

  // output register
  logic        out_valid_q;
  logic [5:0]  lamps_q, lamps_d;
  logic        serving_q, serving_d;

  logic        in_accept;
  phase_desc_t cur_desc;
  phase_desc_t ent_desc;
  logic        enter;
  phase_e      ent_phase;

  // the output register frees up in the cycle its word is taken
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign cur_desc = phase_desc(phase_q);
  assign ent_desc = phase_desc(ent_phase);

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q   <= LONG_PHASE_TICKS_RST;
      half_ticks_q   <= BLINK_HALF_TICKS_RST;
      blink_cycles_q <= BLINK_CYCLES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LONG_PHASE_TICKS: long_ticks_q   <= cfg_data_i;
        REG_BLINK_HALF_TICKS: half_ticks_q   <= cfg_data_i;
        REG_BLINK_CYCLES:     blink_cycles_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // next state: press branch, tick countdown, blink toggle, phase change
  always_comb begin
    phase_d     = phase_q;
    colour_d    = colour_q;
    ticks_d     = ticks_q;
    blinks_d    = blinks_q;
    lit_d       = lit_q;
    sv_phase_d  = sv_phase_q;
    sv_ticks_d  = sv_ticks_q;
    sv_blinks_d = sv_blinks_q;
    sv_lit_d    = sv_lit_q;
    enter       = 1'b0;
    ent_phase   = cur_desc.nxt;

    if (press_i && is_normal(phase_q)) begin
      // remember where the normal loop stopped
      sv_phase_d  = phase_q[1:0];
      sv_ticks_d  = ticks_q;
      sv_blinks_d = blinks_q;
      sv_lit_d    = lit_q;
      enter       = 1'b1;
      case (colour_q)
        COL_RED:    ent_phase = PH_RR_WALK;
        COL_YELLOW: ent_phase = PH_RY_CLEAR;
        default:    ent_phase = PH_RG_CLEAR;
      endcase
    end else if (tick_i) begin
      if (ticks_q > 16'd1) begin
        ticks_d = ticks_q - 16'd1;
      end else if (cur_desc.blinking && lit_q) begin
        // lit half over, start the dark half
        lit_d   = 1'b0;
        ticks_d = half_ticks_q;
      end else if (cur_desc.blinking && (blinks_q > 4'd1)) begin
        blinks_d = blinks_q - 4'd1;
        lit_d    = 1'b1;
        ticks_d  = half_ticks_q;
      end else if (cur_desc.resume) begin
        // pedestrian sequence done, back to the saved phase
        phase_d  = phase_e'({3'b000, sv_phase_q});
        ticks_d  = sv_ticks_q;
        blinks_d = sv_blinks_q;
        lit_d    = sv_lit_q;
      end else begin
        enter = 1'b1;
      end
    end

    // load a fresh phase
    if (enter) begin
      phase_d = ent_phase;
      if (ent_desc.blinking) begin
        blinks_d = blink_cycles_q;
        lit_d    = 1'b1;
        ticks_d  = half_ticks_q;
      end else begin
        blinks_d = 4'd0;
        lit_d    = 1'b0;
        ticks_d  = long_ticks_q;
      end
      if (is_normal(ent_phase)) begin
        colour_d = ent_desc.colour;
      end
    end
  end

  // lamp decode of the state after the step
  phase_desc_t nxt_desc;
  assign nxt_desc = phase_desc(phase_d);

  always_comb begin
    lamps_d   = nxt_desc.steady | (lit_d ? nxt_desc.flashing : LAMP_NONE);
    serving_d = ~is_normal(phase_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NORM_GREEN;
      colour_q    <= COL_GREEN;
      ticks_q     <= LONG_PHASE_TICKS_RST;
      blinks_q    <= 4'd0;
      lit_q       <= 1'b0;
      sv_phase_q  <= 2'd0;
      sv_ticks_q  <= 16'd0;
      sv_blinks_q <= 4'd0;
      sv_lit_q    <= 1'b0;
    end else if (in_accept) begin
      phase_q     <= phase_d;
      colour_q    <= colour_d;
      ticks_q     <= ticks_d;
      blinks_q    <= blinks_d;
      lit_q       <= lit_d;
      sv_phase_q  <= sv_phase_d;
      sv_ticks_q  <= sv_ticks_d;
      sv_blinks_q <= sv_blinks_d;
      sv_lit_q    <= sv_lit_d;
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lamps_q   <= lamps_d;
      serving_q <= serving_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign car_red_o         = lamps_q[0];
  assign car_yellow_o      = lamps_q[1];
  assign car_green_o       = lamps_q[2];
  assign walk_red_o        = lamps_q[3];
  assign walk_yellow_o     = lamps_q[4];
  assign walk_green_o      = lamps_q[5];
  assign serving_request_o = serving_q;

endmodule
